/* rtl/arp_pkg.sv */
package arp_pkg;

    // Default number of CORDIC micro-rotations and the size of the arctangent table
    localparam int unsigned ROT_ITERATIONS_DEF = 16;
    localparam int unsigned ATAN_ENTRIES       = 24;

    // Coordinate, angle and internal widths
    localparam int unsigned COORD_W = 32;
    localparam int unsigned ANGLE_W = 16;
    localparam int unsigned WRAP_W  = 36;   // angle widened to Q.30, before the 2*pi wrap
    localparam int unsigned RES_W   = 33;   // residual angle after the 2*pi wrap
    localparam int unsigned CORD_W  = 34;   // CORDIC x/y datapath, Q.30
    localparam int unsigned PROD_W  = 2 * COORD_W;
    localparam int unsigned ACC_W   = PROD_W + 1;

    // Q.30 constants, truncated toward zero
    localparam logic signed [WRAP_W-1:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [WRAP_W-1:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [WRAP_W-1:0] Q30_TWO_PI  = 36'sd6746518852;
    localparam logic signed [CORD_W-1:0] Q30_GAIN    = 34'sd652032874;

    // Axis selector codes
    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } axis_t;

    // atan(2^-i) in Q.30
    function automatic logic [29:0] atan_q30(input int unsigned idx);
        logic [29:0] v;
        case (idx)
            0:       v = 30'd843314856;
            1:       v = 30'd497837829;
            2:       v = 30'd263043836;
            3:       v = 30'd133525158;
            4:       v = 30'd67021686;
            5:       v = 30'd33543515;
            6:       v = 30'd16775850;
            7:       v = 30'd8388437;
            8:       v = 30'd4194282;
            9:       v = 30'd2097149;
            10:      v = 30'd1048575;
            11:      v = 30'd524287;
            12:      v = 30'd262143;
            13:      v = 30'd131071;
            14:      v = 30'd65535;
            15:      v = 30'd32767;
            16:      v = 30'd16383;
            17:      v = 30'd8191;
            18:      v = 30'd4095;
            19:      v = 30'd2047;
            20:      v = 30'd1023;
            21:      v = 30'd511;
            22:      v = 30'd255;
            23:      v = 30'd127;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // Round a Q19.46 sum to Q16.16 (half up) and saturate to 32 bits
    function automatic logic [COORD_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] r;
        logic [COORD_W-1:0]      res;
        r = (acc + $signed({{(ACC_W-30){1'b0}}, 30'h2000_0000})) >>> 30;
        if (r[ACC_W-1:COORD_W-1] == '0 || r[ACC_W-1:COORD_W-1] == '1)
            res = r[COORD_W-1:0];
        else if (r[ACC_W-1])
            res = {1'b1, {(COORD_W-1){1'b0}}};
        else
            res = {1'b0, {(COORD_W-1){1'b1}}};
        return res;
    endfunction

endpackage

/* rtl/axis_rotate_point_unit.sv */
// Order of registers: stage W, CORDIC stages 0 to ROT_ITERATIONS, stage F, stage M, output.
// Throughput: one item per cycle unless the output stalls; each CORDIC micro-rotation is its
// own pipeline stage, followed by a sign/operand stage, a 32x32 multiply stage and a
// round/saturate stage. A stalled output freezes the whole pipeline; in_ready is low only
// while out_valid waits. Reset clears all valid bits; the datapath registers are not reset.
module axis_rotate_point_unit
    import arp_pkg::*;
#(
    parameter int unsigned ROT_ITERATIONS = ROT_ITERATIONS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COORD_W-1:0] in_x,
    input  logic signed [COORD_W-1:0] in_y,
    input  logic signed [COORD_W-1:0] in_z,
    input  logic        [1:0]         rot_axis,
    input  logic signed [ANGLE_W-1:0] angle,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [COORD_W-1:0] out_x,
    output logic signed [COORD_W-1:0] out_y,
    output logic signed [COORD_W-1:0] out_z
);

    localparam int unsigned N = ROT_ITERATIONS;
    localparam logic signed [RES_W-1:0] RES_BOUND =
        $signed({2'b00, atan_q30(N - 1), 1'b0});

    // Pipeline advance: all stages move together unless the output item is held
    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // ---------------- Stage W: widen angle and wrap by 2*pi ----------------
    logic signed [WRAP_W-1:0] t_in;
    logic signed [WRAP_W-1:0] t_wrap;

    assign t_in = $signed({{(WRAP_W-ANGLE_W-18){angle[ANGLE_W-1]}}, angle, 18'b0});

    always_comb
    begin
        if (t_in > Q30_PI)
            t_wrap = t_in - Q30_TWO_PI;
        else if (t_in < -Q30_PI)
            t_wrap = t_in + Q30_TWO_PI;
        else
            t_wrap = t_in;
    end

    logic                      w_vld_reg;
    logic signed [RES_W-1:0]   w_t_reg;
    logic signed [COORD_W-1:0] w_x_reg, w_y_reg, w_z_reg;
    axis_t                     w_axis_reg;

    // ---------------- Stage 0: fold into [-pi/2, pi/2] ----------------
    logic signed [WRAP_W-1:0] w_t_ext;
    logic signed [WRAP_W-1:0] t_fold;
    logic                     fold_flip;

    assign w_t_ext = $signed({{(WRAP_W-RES_W){w_t_reg[RES_W-1]}}, w_t_reg});

    always_comb
    begin
        fold_flip = 1'b0;
        t_fold    = w_t_ext;
        if (w_t_ext > Q30_HALF_PI)
        begin
            t_fold    = w_t_ext - Q30_PI;
            fold_flip = 1'b1;
        end
        else if (w_t_ext < -Q30_HALF_PI)
        begin
            t_fold    = w_t_ext + Q30_PI;
            fold_flip = 1'b1;
        end
    end

    // CORDIC stage k holds the state after k micro-rotations
    logic                      cv_reg   [0:N];
    logic signed [CORD_W-1:0]  cx_reg   [0:N];
    logic signed [CORD_W-1:0]  cy_reg   [0:N];
    logic signed [RES_W-1:0]   ct_reg   [0:N];
    logic                      cf_reg   [0:N];
    logic signed [COORD_W-1:0] cpx_reg  [0:N];
    logic signed [COORD_W-1:0] cpy_reg  [0:N];
    logic signed [COORD_W-1:0] cpz_reg  [0:N];
    axis_t                     cax_reg  [0:N];

    // ---------------- Stage F: final signs, operand select ----------------
    logic                      f_vld_reg;
    logic signed [COORD_W-1:0] f_c_reg, f_s_reg, f_u_reg, f_v_reg;
    logic signed [COORD_W-1:0] f_x_reg, f_y_reg, f_z_reg;
    axis_t                     f_axis_reg;

    logic signed [CORD_W-1:0]  c_next, s_next;
    logic signed [COORD_W-1:0] u_next, v_next;
    logic                      s_neg;

    always_comb
    begin
        // Axis y uses -s on the same pair form; combine with the fold flip
        s_neg  = cf_reg[N] ^ (cax_reg[N] == AXIS_Y);
        c_next = cf_reg[N] ? -cx_reg[N] : cx_reg[N];
        s_next = s_neg ? -cy_reg[N] : cy_reg[N];
        case (cax_reg[N])
            AXIS_X:
            begin
                u_next = cpy_reg[N];
                v_next = cpz_reg[N];
            end
            AXIS_Y:
            begin
                u_next = cpx_reg[N];
                v_next = cpz_reg[N];
            end
            default:
            begin
                u_next = cpx_reg[N];
                v_next = cpy_reg[N];
            end
        endcase
    end

    // ---------------- Stage M: four products ----------------
    logic                      m_vld_reg;
    logic signed [PROD_W-1:0]  m_cu_reg, m_sv_reg, m_cv_reg, m_su_reg;
    logic signed [COORD_W-1:0] m_x_reg, m_y_reg, m_z_reg;
    axis_t                     m_axis_reg;

    // ---------------- Stage A: sum, round, saturate, place ----------------
    logic signed [ACC_W-1:0]   acc1, acc2;
    logic        [COORD_W-1:0] r1, r2;
    logic signed [COORD_W-1:0] out_x_next, out_y_next, out_z_next;

    assign acc1 = $signed({m_cu_reg[PROD_W-1], m_cu_reg})
                + $signed({m_sv_reg[PROD_W-1], m_sv_reg});
    assign acc2 = $signed({m_cv_reg[PROD_W-1], m_cv_reg})
                - $signed({m_su_reg[PROD_W-1], m_su_reg});
    assign r1 = round_sat(acc1);
    assign r2 = round_sat(acc2);

    always_comb
    begin
        out_x_next = m_x_reg;
        out_y_next = m_y_reg;
        out_z_next = m_z_reg;
        unique case (m_axis_reg)
            AXIS_X:
            begin
                out_y_next = $signed(r1);
                out_z_next = $signed(r2);
            end
            AXIS_Y:
            begin
                out_x_next = $signed(r1);
                out_z_next = $signed(r2);
            end
            AXIS_Z:
            begin
                out_x_next = $signed(r1);
                out_y_next = $signed(r2);
            end
            default:
            begin
                out_x_next = m_x_reg;
            end
        endcase
    end

    logic                      out_valid_reg;
    logic signed [COORD_W-1:0] out_x_reg, out_y_reg, out_z_reg;

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_vld_reg     <= 1'b0;
            f_vld_reg     <= 1'b0;
            m_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= N; k++)
            begin
                cv_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            w_vld_reg <= in_valid;
            cv_reg[0] <= w_vld_reg;
            for (int k = 0; k < N; k++)
            begin
                cv_reg[k+1] <= cv_reg[k];
            end
            f_vld_reg     <= cv_reg[N];
            m_vld_reg     <= f_vld_reg;
            out_valid_reg <= m_vld_reg;
        end
    end

    // Datapath: advance every stage together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_t_reg    <= t_wrap[RES_W-1:0];
            w_x_reg    <= in_x;
            w_y_reg    <= in_y;
            w_z_reg    <= in_z;
            w_axis_reg <= axis_t'(rot_axis);

            cx_reg[0]  <= Q30_GAIN;
            cy_reg[0]  <= '0;
            ct_reg[0]  <= t_fold[RES_W-1:0];
            cf_reg[0]  <= fold_flip;
            cpx_reg[0] <= w_x_reg;
            cpy_reg[0] <= w_y_reg;
            cpz_reg[0] <= w_z_reg;
            cax_reg[0] <= w_axis_reg;

            // One micro-rotation per stage
            for (int k = 0; k < N; k++)
            begin
                if (!ct_reg[k][RES_W-1])
                begin
                    cx_reg[k+1] <= cx_reg[k] - (cy_reg[k] >>> k);
                    cy_reg[k+1] <= cy_reg[k] + (cx_reg[k] >>> k);
                    ct_reg[k+1] <= ct_reg[k] - $signed({3'b000, atan_q30(k)});
                end
                else
                begin
                    cx_reg[k+1] <= cx_reg[k] + (cy_reg[k] >>> k);
                    cy_reg[k+1] <= cy_reg[k] - (cx_reg[k] >>> k);
                    ct_reg[k+1] <= ct_reg[k] + $signed({3'b000, atan_q30(k)});
                end
                cf_reg[k+1]  <= cf_reg[k];
                cpx_reg[k+1] <= cpx_reg[k];
                cpy_reg[k+1] <= cpy_reg[k];
                cpz_reg[k+1] <= cpz_reg[k];
                cax_reg[k+1] <= cax_reg[k];
            end

            // cos and sin stay within about 1.0 in Q.30, so 32 bits hold them
            f_c_reg    <= c_next[COORD_W-1:0];
            f_s_reg    <= s_next[COORD_W-1:0];
            f_u_reg    <= u_next;
            f_v_reg    <= v_next;
            f_x_reg    <= cpx_reg[N];
            f_y_reg    <= cpy_reg[N];
            f_z_reg    <= cpz_reg[N];
            f_axis_reg <= cax_reg[N];

            m_cu_reg   <= f_c_reg * f_u_reg;
            m_sv_reg   <= f_s_reg * f_v_reg;
            m_cv_reg   <= f_c_reg * f_v_reg;
            m_su_reg   <= f_s_reg * f_u_reg;
            m_x_reg    <= f_x_reg;
            m_y_reg    <= f_y_reg;
            m_z_reg    <= f_z_reg;
            m_axis_reg <= f_axis_reg;

            out_x_reg  <= out_x_next;
            out_y_reg  <= out_y_next;
            out_z_reg  <= out_z_next;
        end
    end

    // Folded angle lies within [-pi/2, pi/2]
    assert property (@(posedge clk) disable iff (!rst_n)
        cv_reg[0] |-> (ct_reg[0] <= $signed(Q30_HALF_PI[RES_W-1:0]))
                   && (ct_reg[0] >= -$signed(Q30_HALF_PI[RES_W-1:0])))
        else $error("folded angle out of range");

    // Residual angle has converged after the last micro-rotation
    assert property (@(posedge clk) disable iff (!rst_n)
        cv_reg[N] |-> (ct_reg[N] <= RES_BOUND) && (ct_reg[N] >= -RES_BOUND))
        else $error("CORDIC residual did not converge");

    // A stall freezes the valid bits of stages W, CORDIC 0, CORDIC N, F and M
    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(w_vld_reg) && $stable(cv_reg[0]) && $stable(cv_reg[N])
                && $stable(f_vld_reg) && $stable(m_vld_reg))
        else $error("pipeline moved during a stall");

    // An item in the multiply stage reaches the output on the next advance
    assert property (@(posedge clk) disable iff (!rst_n)
        en && m_vld_reg |=> out_valid)
        else $error("item lost between multiply stage and output");

endmodule
